// ===== src/limbs_to_pow2_radix_digits_macros.svh =====
// Assertion macros used by the radix digit engine RTL.
`ifndef LIMBS_TO_POW2_RADIX_DIGITS_MACROS_SVH
`define LIMBS_TO_POW2_RADIX_DIGITS_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define L2R_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("l2r assertion failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define L2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("l2r assertion failed");

`endif

// ===== src/l2r_pkg.sv =====
// Types, constants and helper functions of the radix digit generator.
package l2r_pkg;

  // Fixed field widths of the channels.
  localparam int LIMB_FIELD_W = 64;
  localparam int DIGIT_W      = 8;
  localparam int DVAL_W       = 5;

  // Register reset values.
  localparam logic [2:0] DIGIT_BITS_RST = 3'd4;
  localparam logic       CHAR_MODE_RST  = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_DIGIT_BITS = 1'b0,
    REG_CHAR_MODE  = 1'b1
  } reg_idx_t;

  // Engine states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } eng_state_t;

  // Configuration seen by the engine.
  typedef struct packed {
    logic [2:0] bits;
    logic       clear;
  } eng_cfg_t;

  // One digit leaving the engine.
  typedef struct packed {
    logic [DVAL_W-1:0] value;
    logic              last;
  } digit_t;

  // Digit width in use: zero acts as one, six and seven act as five.
  function automatic logic [2:0] eff_digit_bits(input logic [2:0] raw);
    logic [2:0] d;
    d = raw;
    if (raw == 3'd0) begin
      d = 3'd1;
    end else if (raw > 3'd5) begin
      d = 3'd5;
    end
    return d;
  endfunction

  // ASCII character of a digit value: 0-9 then a-v.
  function automatic logic [DIGIT_W-1:0] to_char(input logic [DVAL_W-1:0] v);
    logic [DIGIT_W-1:0] c;
    if (v < 5'd10) begin
      c = 8'h30 + {3'b000, v};
    end else begin
      c = 8'h61 + {3'b000, v} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== src/l2r_in_if.sv =====
// Input channel: one limb of the number per item.
interface l2r_in_if import l2r_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [LIMB_FIELD_W-1:0] limb;
  logic                    last_limb;

  modport source (output valid, output limb, output last_limb, input ready);
  modport sink   (input valid, input limb, input last_limb, output ready);
endinterface

// ===== src/l2r_out_if.sv =====
// Result channel: one digit or character per item.
interface l2r_out_if import l2r_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

// ===== src/l2r_engine.sv =====
// Digit-serial engine: shifts a limb out one digit per cycle unless stalled, carrying leftover bits.
`include "limbs_to_pow2_radix_digits_macros.svh"

module l2r_engine import l2r_pkg::*; #(
  parameter int LIMB_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [LIMB_WIDTH-1:0] in_limb,
  input  logic                  in_last,
  output logic                  in_ready,
  input  eng_cfg_t              cfg,
  output logic                  dig_valid,
  output digit_t                dig,
  input  logic                  dig_ready
);

  localparam int RW = $clog2(LIMB_WIDTH + 1);

  eng_state_t            state_r, state_nxt;
  logic [LIMB_WIDTH-1:0] x_r, x_nxt;
  logic [RW-1:0]         rest_r, rest_nxt;
  logic                  top_r, top_nxt;
  logic [3:0]            pb_r, pb_nxt;
  logic [2:0]            pc_r, pc_nxt;

  logic [2:0]            take;
  logic [DVAL_W-1:0]     take_mask;
  logic [3:0]            pb_m;
  logic [LIMB_WIDTH-1:0] x_shift;
  logic                  more;
  logic                  emit;
  logic                  park;
  logic                  fire;

  // Digit assembly: pending bits below, fresh limb bits above them.
  always_comb begin
    take      = cfg.bits - pc_r;
    take_mask = DVAL_W'((6'd1 << take) - 6'd1);
    pb_m      = pb_r & 4'((5'd1 << pc_r) - 5'd1);
    x_shift   = x_r >> take;
    more      = rest_r >= RW'(take);
    emit      = (state_r == ST_RUN) && (top_r || more);
    park      = (state_r == ST_RUN) && !top_r && !more;
    fire      = emit && dig_ready;
    dig.value = {1'b0, pb_m} | DVAL_W'((x_r[DVAL_W-1:0] & take_mask) << pc_r);
    dig.last  = top_r && (x_shift == '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (park || (fire && dig.last)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    dig_valid = emit;
  end

  // Datapath next values.
  always_comb begin
    x_nxt    = x_r;
    rest_nxt = rest_r;
    top_nxt  = top_r;
    pb_nxt   = pb_r;
    pc_nxt   = pc_r;
    priority if (in_valid && in_ready) begin
      x_nxt    = in_limb;
      rest_nxt = RW'(LIMB_WIDTH);
      top_nxt  = in_last;
    end else if (cfg.clear) begin
      pb_nxt = 4'd0;
      pc_nxt = 3'd0;
    end else if (park) begin
      pb_nxt = x_r[3:0];
      pc_nxt = rest_r[2:0];
    end else if (fire) begin
      x_nxt    = x_shift;
      rest_nxt = rest_r - RW'(take);
      pc_nxt   = 3'd0;
      if (dig.last) begin
        pb_nxt = 4'd0;
      end
    end else begin
      // Idle or stalled: the shift register keeps its contents.
      x_nxt = x_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pb_r    <= 4'd0;
      pc_r    <= 3'd0;
    end else begin
      state_r <= state_nxt;
      pb_r    <= pb_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // Shift register and bit counter.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    rest_r <= rest_nxt;
    top_r  <= top_nxt;
  end

  // Checks on the engine's own sequencing.
  `L2R_ASSERT_IMPL(a_pending_fits, state_r == ST_RUN, pc_r < cfg.bits)
  `L2R_ASSERT_NEXT(a_last_ends, fire && dig.last, state_r == ST_IDLE && pc_r == 3'd0)
  `L2R_ASSERT_IMPL(a_inner_not_last, dig_valid && !top_r, !dig.last)
  `L2R_ASSERT_NEXT(a_accept_runs, in_valid && in_ready, state_r == ST_RUN)

endmodule

// ===== src/limbs_to_pow2_radix_digits.sv =====
// Top level: configuration registers, digit engine and output register.
//
// Takes the limbs of an unsigned big integer, least significant first, and emits its
// digits in base 2^digit_bits least significant first, as raw values or ASCII, with
// the top digit marked and no leading zeros. A limb is accepted while the engine is idle,
// then the shift register produces one digit per cycle unless the output stalls: a top
// limb yields digits up to its highest set bit, an inner limb yields its full digits and
// then parks its leftover bits for the next limb. The output register stalls the engine
// while a digit waits.
module limbs_to_pow2_radix_digits import l2r_pkg::*; #(
  parameter int LIMB_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  l2r_in_if.sink      in_ch,
  l2r_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [2:0]         digit_bits_r;
  logic               char_mode_r;
  logic               out_valid_r;
  logic [DIGIT_W-1:0] out_digit_r;
  logic               out_last_r;

  reg_idx_t           reg_idx;
  logic               cfg_wr;
  eng_cfg_t           eng_cfg;
  logic               dig_valid;
  digit_t             dig;
  logic               dig_ready;

  // Register decode.
  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (reg_idx)
      REG_DIGIT_BITS: cfg_prdata = {29'd0, digit_bits_r};
      REG_CHAR_MODE:  cfg_prdata = {31'd0, char_mode_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_bits_r <= DIGIT_BITS_RST;
      char_mode_r  <= CHAR_MODE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DIGIT_BITS: digit_bits_r <= cfg_pwdata[2:0];
        REG_CHAR_MODE:  char_mode_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // A new digit width abandons any leftover bits.
  assign eng_cfg.bits  = eff_digit_bits(digit_bits_r);
  assign eng_cfg.clear = cfg_wr && (reg_idx == REG_DIGIT_BITS);

  l2r_engine #(
    .LIMB_WIDTH (LIMB_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_limb   (in_ch.limb[LIMB_WIDTH-1:0]),
    .in_last   (in_ch.last_limb),
    .in_ready  (in_ch.ready),
    .cfg       (eng_cfg),
    .dig_valid (dig_valid),
    .dig       (dig),
    .dig_ready (dig_ready)
  );

  // Output register: loads when empty or being drained.
  assign dig_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dig_ready) begin
      out_valid_r <= dig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_valid && dig_ready) begin
      out_digit_r <= char_mode_r ? to_char(dig.value) : {3'b000, dig.value};
      out_last_r  <= dig.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.digit      = out_digit_r;
  assign out_ch.last_digit = out_last_r;

endmodule

// ===== dv/limbs_to_pow2_radix_digits_checker.sv =====
// Checker for the radix digit generator: follows the registers, predicts digits and compares.
module limbs_to_pow2_radix_digits_checker import l2r_pkg::*; #(
  parameter int LIMB_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  l2r_in_if           in_ch,
  l2r_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  input  logic        run_done,
  output int          mismatches,
  output int          digits_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected digit: its code on the wire and the top-digit mark.
  typedef struct packed {
    logic [DIGIT_W-1:0] code;
    logic               top;
  } digit_exp_t;

  digit_exp_t  due_q[$];
  logic [2:0]  width_reg;
  logic        ascii_reg;
  logic [3:0]  carry_bits;
  int          carry_cnt;
  int          fail_cnt = 0;
  int          due_cnt = 0;
  int          digits_seen = 0;
  bit          end_checked = 1'b0;

  assign mismatches = fail_cnt;
  assign digits_due = due_cnt;

  task automatic report(input string what);
    $display("[%0t] digit check: %s", $time, what);
    fail_cnt++;
  endtask

  // Bits per digit actually used: zero acts as one, six and seven act as five.
  function automatic int width_in_use(input logic [2:0] raw);
    if (raw == 3'd0) begin
      return 1;
    end else if (raw > 3'd5) begin
      return 5;
    end
    return int'(raw);
  endfunction

  // Raw value, or ASCII 0-9 followed by a-v.
  function automatic logic [DIGIT_W-1:0] encode(input logic [DVAL_W-1:0] v, input logic ascii);
    if (!ascii) begin
      return {3'b000, v};
    end else if (v < 5'd10) begin
      return 8'h30 + {3'b000, v};
    end
    return 8'h57 + {3'b000, v};
  endfunction

  function automatic void push_digit(input logic [63:0] v, input logic top);
    digit_exp_t e;
    e.code = encode(v[DVAL_W-1:0], ascii_reg);
    e.top  = top;
    due_q.push_back(e);
  endfunction

  // Regroup one limb into digits, joining the bits held over from the previous limb.
  task automatic expand_limb(input logic [63:0] limb, input logic top);
    int          d;
    int          pc;
    int          fix;
    int          rest;
    logic [63:0] x;
    logic [63:0] v;
    logic [63:0] dmask;
    d     = width_in_use(width_reg);
    dmask = (64'd1 << d) - 64'd1;
    x     = limb & ({64{1'b1}} >> (64 - LIMB_WIDTH));
    pc    = carry_cnt;
    fix   = d - pc;
    v     = ({60'd0, carry_bits} & ((64'd1 << pc) - 64'd1)) |
            ((x & ((64'd1 << fix) - 64'd1)) << pc);
    if (!top) begin
      rest = LIMB_WIDTH;
      if (pc != 0) begin
        push_digit(v, 1'b0);
        x = x >> fix;
        rest -= fix;
      end
      while (rest >= d) begin
        push_digit(x & dmask, 1'b0);
        x = x >> d;
        rest -= d;
      end
      carry_bits = x[3:0];
      carry_cnt  = rest;
    end else begin
      // A zero top limb still counts as one significant bit.
      rest = 1;
      for (int i = 0; i < LIMB_WIDTH; i++) begin
        if (x[i]) begin
          rest = i + 1;
        end
      end
      carry_bits = '0;
      carry_cnt  = 0;
      if (pc != 0) begin
        if (rest <= fix) begin
          push_digit(v, 1'b1);
          rest = 0;
        end else begin
          push_digit(v, 1'b0);
          x = x >> fix;
          rest -= fix;
        end
      end
      while (rest > 0) begin
        push_digit(x & dmask, rest <= d);
        x = x >> d;
        rest -= d;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    digit_exp_t want;
    if (!rst_n) begin
      width_reg  = DIGIT_BITS_RST;
      ascii_reg  = CHAR_MODE_RST;
      carry_bits = '0;
      carry_cnt  = 0;
      due_q.delete();
    end else begin
      // Register writes; a new digit width drops any number in progress.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (reg_idx_t'(cfg_paddr[2]) == REG_DIGIT_BITS) begin
          width_reg  = cfg_pwdata[2:0];
          carry_bits = '0;
          carry_cnt  = 0;
        end else begin
          ascii_reg = cfg_pwdata[0];
        end
      end
      // Compare each accepted digit with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report($sformatf("digit %0d: unexpected code %02h last %0b", digits_seen,
                           out_ch.digit, out_ch.last_digit));
        end else begin
          want = due_q.pop_front();
          if (out_ch.digit !== want.code) begin
            report($sformatf("digit %0d: code %02h, expected %02h", digits_seen,
                             out_ch.digit, want.code));
          end
          if (out_ch.last_digit !== want.top) begin
            report($sformatf("digit %0d: last_digit %0b, expected %0b", digits_seen,
                             out_ch.last_digit, want.top));
          end
        end
        digits_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        expand_limb(in_ch.limb, in_ch.last_limb);
      end
      // Anything still predicted when the run closes was never delivered.
      if (run_done && !end_checked) begin
        end_checked = 1'b1;
        if (due_q.size() != 0) begin
          report($sformatf("%0d predicted digits never arrived", due_q.size()));
        end
      end
    end
    due_cnt = due_q.size();
  end

endmodule

// ===== dv/limbs_to_pow2_radix_digits_tb.sv =====
// Testbench top for the radix digit generator: clock, reset, stimulus and verdict.
module limbs_to_pow2_radix_digits_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import l2r_pkg::*;

  localparam int LIMB_W       = 64;
  localparam int TARGET_ITEMS = 460;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 2 * LIMB_W + 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        run_done;
  int          mismatches;
  int          digits_due;
  int          items_sent;
  int          cycles = 0;
  bit          calm;
  bit          hold_out;

  l2r_in_if  in_ch();
  l2r_out_if out_ch();

  limbs_to_pow2_radix_digits #(.LIMB_WIDTH(LIMB_W)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  limbs_to_pow2_radix_digits_checker #(.LIMB_WIDTH(LIMB_W)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .run_done    (run_done),
    .mismatches  (mismatches),
    .digits_due  (digits_due)
  );

  always #5ns clk = ~clk;

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Top limbs: zero, all ones, single bits and every bit length.
  function automatic logic [63:0] top_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = '1;
      2: r = 64'd1 << $urandom_range(0, 63);
      3, 4: r = r >> $urandom_range(0, 63);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] inner_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r = '0;
      1: r = '1;
      default: ;
    endcase
    return r;
  endfunction

  // Offer one limb after a random gap and hold it until the block takes it.
  task automatic send_limb(input logic [63:0] limb, input logic top);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.limb      <= limb;
    in_ch.last_limb <= top;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_number(input int n_inner);
    repeat (n_inner) send_limb(inner_value(), 1'b0);
    send_limb(top_value(), 1'b1);
  endtask

  // Stop offering, wait for every predicted digit, then let the engine settle.
  task automatic drain(input int settle);
    in_ch.valid <= 1'b0;
    while (digits_due != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Setup, access, then idle on the register port.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // One random phase: new settings, a few whole numbers, sometimes a dangling limb.
  task automatic random_phase();
    calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 5) != 0) begin
      write_reg(REG_DIGIT_BITS, 32'($urandom_range(0, 7)));
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_CHAR_MODE, 32'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(1, 5)) send_number($urandom_range(0, 3));
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) send_limb(inner_value(), 1'b0);
    end
    drain(SETTLE);
  endtask

  // Result side: random stalls per item, plus one long hold on request.
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.limb      = '0;
    in_ch.last_limb = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    run_done        = 1'b0;
    calm            = 1'b0;
    hold_out        = 1'b0;
    items_sent      = 0;
    rst_n           = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, hex characters: zero, full, lowest and highest bit as top limbs.
    send_limb(64'd0, 1'b1);
    send_limb('1, 1'b1);
    send_limb(64'd1, 1'b1);
    send_limb(64'h8000_0000_0000_0000, 1'b1);
    drain(SETTLE);

    // Octal raw values: leftover bits carried across limbs, and a zero top limb
    // that only closes the held bits.
    write_reg(REG_DIGIT_BITS, 32'd3);
    write_reg(REG_CHAR_MODE, 32'd0);
    send_limb('1, 1'b0);
    send_limb(64'd0, 1'b0);
    send_limb(64'd5, 1'b1);
    send_limb(inner_value(), 1'b0);
    send_limb(64'd0, 1'b1);
    drain(SETTLE);

    // Base 32 characters up to 'v', with four bits held between limbs.
    write_reg(REG_DIGIT_BITS, 32'd5);
    write_reg(REG_CHAR_MODE, 32'd1);
    send_limb('1, 1'b0);
    send_limb('1, 1'b0);
    send_limb('1, 1'b1);
    send_limb(inner_value(), 1'b0);
    send_limb(64'd1, 1'b1);
    drain(SETTLE);

    // Width zero acts as binary: a full top limb gives the most digits per item.
    write_reg(REG_DIGIT_BITS, 32'd0);
    send_limb('1, 1'b1);
    send_limb(inner_value(), 1'b0);
    send_limb(64'd0, 1'b1);
    drain(SETTLE);

    // Widths six and seven act as five.
    write_reg(REG_DIGIT_BITS, 32'd6);
    send_limb(top_value(), 1'b1);
    drain(SETTLE);
    write_reg(REG_DIGIT_BITS, 32'd7);
    send_limb({$urandom, $urandom}, 1'b1);
    drain(SETTLE);

    // A width write drops the bits held from an unfinished number.
    write_reg(REG_DIGIT_BITS, 32'd3);
    send_limb('1, 1'b0);
    drain(SETTLE);
    write_reg(REG_DIGIT_BITS, 32'd3);
    send_limb(64'd0, 1'b1);
    drain(SETTLE);

    // A character mode write keeps them.
    write_reg(REG_DIGIT_BITS, 32'd5);
    send_limb('1, 1'b0);
    drain(SETTLE);
    write_reg(REG_CHAR_MODE, 32'd0);
    send_limb(64'd0, 1'b1);
    drain(SETTLE);

    // Long hold on the result side while limbs keep coming, so the input backs up.
    write_reg(REG_DIGIT_BITS, 32'd1);
    calm     = 1'b1;
    hold_out = 1'b1;
    repeat (4) send_number($urandom_range(0, 2));
    drain(SETTLE);

    while (items_sent < TARGET_ITEMS) begin
      random_phase();
    end

    drain(TAIL);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
